// ----- rtl/core/bdr_pkg.sv -----
// Shared constants, codes and types for the bounded deque ring.
// No dependencies; every other file of the block except bdr_ram refers to this package.
`timescale 1ns / 1ps

package bdr_pkg;

  localparam int WORD_W    = 32;
  localparam int KIND_W    = 2;
  localparam int STAT_W    = 2;
  localparam int DEPTH_DEF = 16;

  // operation codes carried in the kind field
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // command from the control to the pointer unit
  typedef struct packed {
    logic apply;     // commit the operation to the pointers
    logic push;      // push (else pop)
    logic at_front;  // front end (else back end)
  } bdr_cmd_t;

endpackage

// ----- rtl/core/bdr_in_if.sv -----
// Input channel of the bounded deque ring: valid/ready plus operation beat.
// Depends on bdr_pkg.
`timescale 1ns / 1ps

interface bdr_in_if;
  logic                             valid;
  logic                             ready;
  logic [bdr_pkg::KIND_W-1:0]       kind;
  logic signed [bdr_pkg::WORD_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// ----- rtl/core/bdr_out_if.sv -----
// Result channel of the bounded deque ring: valid/ready plus result beat.
// Depends on bdr_pkg; CNT_W follows the ring depth.
`timescale 1ns / 1ps

interface bdr_out_if #(
  parameter int CNT_W = $clog2(bdr_pkg::DEPTH_DEF + 1)
);
  logic                              valid;
  logic                              ready;
  logic signed [bdr_pkg::WORD_W-1:0] popped;
  logic [bdr_pkg::STAT_W-1:0]        status;
  logic [CNT_W-1:0]                  item_count;
  logic signed [bdr_pkg::WORD_W-1:0] front_word;
  logic signed [bdr_pkg::WORD_W-1:0] back_word;

  modport source (output valid, output popped, output status, output item_count,
                  output front_word, output back_word, input ready);
  modport sink   (input valid, input popped, input status, input item_count,
                  input front_word, input back_word, output ready);
endinterface

// ----- rtl/core/bdr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bdr_ptr.sv -----
// Head/tail pointers and fill count of the ring, with the RAM address math.
// Depends on bdr_pkg (bdr_cmd_t).
`timescale 1ns / 1ps

module bdr_ptr #(
  parameter int DEPTH = bdr_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bdr_pkg::bdr_cmd_t cmd,
  output logic [CW-1:0]     count,
  output logic              full,
  output logic              empty,
  output logic [AW-1:0]     wr_addr,
  output logic [AW-1:0]     rd_addr
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;  // next free slot behind the back
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec, tail_dec2;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    return (i == LAST) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
    return (i == '0) ? LAST : i - AW'(1);
  endfunction

  // status flags depend on registered state only; the control reads them to
  // build cmd, so they stay apart from the cmd-driven logic below
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;

  always_comb begin
    head_inc  = wrap_inc(head_r);
    head_dec  = wrap_dec(head_r);
    tail_inc  = wrap_inc(tail_r);
    tail_dec  = wrap_dec(tail_r);
    tail_dec2 = wrap_dec(tail_dec);

    wr_addr = cmd.at_front ? head_dec : tail_r;
    // entry that becomes the new end after a pop
    rd_addr = cmd.at_front ? head_inc : tail_dec2;

    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.apply) begin
      if (cmd.push) begin
        count_nxt = count_r + CW'(1);
        if (cmd.at_front) begin
          head_nxt = head_dec;
        end else begin
          tail_nxt = tail_inc;
        end
      end else begin
        count_nxt = count_r - CW'(1);
        if (cmd.at_front) begin
          head_nxt = head_inc;
        end else begin
          tail_nxt = tail_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && cmd.push) |-> !full)
    else $error("push committed on full ring");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && !cmd.push) |-> !empty)
    else $error("pop committed on empty ring");

endmodule

// ----- rtl/core/bounded_deque_ring_top.sv -----
// Bounded deque ring: double-ended queue of signed 32-bit words in a RAM ring.
// Each accepted input beat goes through EXEC, where the result beat is
// registered; no new beat is taken until the control is back in IDLE, since
// a pop reads the ring RAM for the entry that becomes the new front or back.
// Reset (rst_n, synchronous): queue empty, pointers and count zero; RAM is not
// cleared, since only occupied entries are ever read.
`timescale 1ns / 1ps

module bounded_deque_ring_top #(
  parameter int DEPTH = bdr_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst_n,
  bdr_in_if.sink     in_ch,
  bdr_out_if.source  out_ch
);

  localparam int WW = bdr_pkg::WORD_W;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t                     state_r;
  logic                       out_valid_r;
  logic signed [WW-1:0]       popped_r, front_word_r, back_word_r;
  logic [bdr_pkg::STAT_W-1:0] status_r;
  logic [CW-1:0]              item_count_r;
  // operation held across the RAM read
  logic                       op_push_r, op_front_r;
  logic [bdr_pkg::STAT_W-1:0] op_stat_r;
  logic signed [WW-1:0]       op_val_r, op_popped_r;

  logic                       in_acc;
  logic                       is_push, at_front;
  logic [bdr_pkg::STAT_W-1:0] stat_now;
  logic                       ok;
  logic signed [WW-1:0]       popped_now;
  logic signed [WW-1:0]       front_nxt, back_nxt;

  bdr_pkg::bdr_cmd_t          cmd;
  logic [CW-1:0]              count;
  logic                       full, empty;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [WW-1:0]              rdata;

  // ---------------------------------------------------------------------------
  // Input side: a new beat is taken in IDLE once the result register is free
  // (or is being drained in the same cycle).
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
    in_acc      = in_ch.valid && in_ch.ready;

    is_push  = (in_ch.kind == bdr_pkg::KIND_PUSH_FRONT) ||
               (in_ch.kind == bdr_pkg::KIND_PUSH_BACK);
    at_front = (in_ch.kind == bdr_pkg::KIND_PUSH_FRONT) ||
               (in_ch.kind == bdr_pkg::KIND_POP_FRONT);

    if (is_push && full) begin
      stat_now = bdr_pkg::STAT_FULL;
    end else if (!is_push && empty) begin
      stat_now = bdr_pkg::STAT_EMPTY;
    end else begin
      stat_now = bdr_pkg::STAT_DONE;
    end
    ok = (stat_now == bdr_pkg::STAT_DONE);

    // popped word comes straight from the cached end words
    popped_now = '0;
    if (ok && !is_push) begin
      popped_now = at_front ? front_word_r : back_word_r;
    end

    cmd.apply    = in_acc && ok;
    cmd.push     = is_push;
    cmd.at_front = at_front;
  end

  bdr_ptr #(.DEPTH(DEPTH)) u_ptr (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .count   (count),
    .full    (full),
    .empty   (empty),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr)
  );

  // Push writes in the accept cycle; a pop's read is launched in the same cycle
  // and its data lands in EXEC. Items never overlap, so no forwarding is needed.
  bdr_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (in_acc && ok && is_push),
    .waddr (wr_addr),
    .wdata (in_ch.value),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------------------
  // EXEC: update the cached front/back words. The pointer unit has already
  // committed, so count is the count after this item.
  // ---------------------------------------------------------------------------
  always_comb begin
    front_nxt = front_word_r;
    back_nxt  = back_word_r;
    if (op_stat_r == bdr_pkg::STAT_DONE) begin
      if (op_push_r) begin
        if (count == CW'(1)) begin
          front_nxt = op_val_r;
          back_nxt  = op_val_r;
        end else if (op_front_r) begin
          front_nxt = op_val_r;
        end else begin
          back_nxt = op_val_r;
        end
      end else begin
        if (count == '0) begin
          front_nxt = '0;
          back_nxt  = '0;
        end else if (count == CW'(1)) begin
          // single survivor is the opposite end
          if (op_front_r) begin
            front_nxt = back_word_r;
          end else begin
            back_nxt = front_word_r;
          end
        end else if (op_front_r) begin
          front_nxt = $signed(rdata);
        end else begin
          back_nxt = $signed(rdata);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      popped_r     <= '0;
      status_r     <= bdr_pkg::STAT_DONE;
      item_count_r <= '0;
      front_word_r <= '0;
      back_word_r  <= '0;
      op_push_r    <= 1'b0;
      op_front_r   <= 1'b0;
      op_stat_r    <= bdr_pkg::STAT_DONE;
      op_val_r     <= '0;
      op_popped_r  <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_push_r   <= is_push;
            op_front_r  <= at_front;
            op_stat_r   <= stat_now;
            op_val_r    <= in_ch.value;
            op_popped_r <= popped_now;
            state_r     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          front_word_r <= front_nxt;
          back_word_r  <= back_nxt;
          out_valid_r  <= 1'b1;
          popped_r     <= op_popped_r;
          status_r     <= op_stat_r;
          item_count_r <= count;
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.popped     = popped_r;
  assign out_ch.status     = status_r;
  assign out_ch.item_count = item_count_r;
  assign out_ch.front_word = front_word_r;
  assign out_ch.back_word  = back_word_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##2 out_valid_r)
    else $error("result beat missing two cycles after accept");

  a_empty_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_push && empty) |=> $stable(count))
    else $error("pop on empty ring changed the count");

  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_push && full) |=> $stable(count))
    else $error("push on full ring changed the count");

  a_empty_words_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && count == '0) |-> (front_word_r == '0 && back_word_r == '0))
    else $error("cached end words not cleared on empty ring");

endmodule
